@@ src/u8dec_pkg.sv @@
// Package for the UTF-8 stream decoder: field widths, register map,
// decoder state and result types, and the UTF-8 range limits.
// No dependencies.
`default_nettype none

package u8dec_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int CP_WIDTH   = 21;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   // register index, taken from paddr[2]
   localparam logic REG_REPLACEMENT = 1'b0;

   localparam logic [CP_WIDTH-1:0] REPLACEMENT_RESET = 21'h00FFFD;

   localparam logic [CP_WIDTH-1:0] CP_MIN_2BYTE   = 21'h000080;
   localparam logic [CP_WIDTH-1:0] CP_MIN_3BYTE   = 21'h000800;
   localparam logic [CP_WIDTH-1:0] CP_MIN_4BYTE   = 21'h010000;
   localparam logic [CP_WIDTH-1:0] CP_MAX         = 21'h10FFFF;
   localparam logic [CP_WIDTH-1:0] SURROGATE_LOW  = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURROGATE_HIGH = 21'h00DFFF;
   localparam logic [BYTE_WIDTH-1:0] LEAD_4BYTE_MAX = 8'hF4;

   // sequence length codes (length minus one)
   localparam logic [1:0] SEQ_LEN_1 = 2'd0;
   localparam logic [1:0] SEQ_LEN_2 = 2'd1;
   localparam logic [1:0] SEQ_LEN_3 = 2'd2;
   localparam logic [1:0] SEQ_LEN_4 = 2'd3;

   typedef struct packed {
      logic [1:0]          remaining;
      logic [1:0]          seq_len;
      logic [CP_WIDTH-1:0] partial;
      logic                cont_bad;
   } dec_state_type;

   typedef struct packed {
      logic                valid;
      logic [CP_WIDTH-1:0] code_point;
      logic                replaced;
   } dec_result_type;

endpackage

`default_nettype wire

@@ src/u8dec_csr.sv @@
// Configuration register block: APB-style write/read of the replacement
// code point. Depends on u8dec_pkg.
`default_nettype none

module u8dec_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [u8dec_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [u8dec_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [u8dec_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                       pready,
   output logic      [u8dec_pkg::CP_WIDTH-1:0]        replacement
);
   import u8dec_pkg::*;

   logic [CP_WIDTH-1:0] repl_ff;
   logic [CP_WIDTH-1:0] repl_in;
   logic                write_hit;

   assign pready    = 1'b1;
   assign write_hit = psel && penable && pwrite && (paddr[2] == REG_REPLACEMENT);

   always_comb begin
      repl_in = repl_ff;
      if (write_hit) begin
         repl_in = pwdata[CP_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPLACEMENT_RESET;
      end else begin
         repl_ff <= repl_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_REPLACEMENT) begin
         prdata = {{(CSR_DATA_WIDTH-CP_WIDTH){1'b0}}, repl_ff};
      end
   end

   assign replacement = repl_ff;

endmodule

`default_nettype wire

@@ src/u8dec_decode.sv @@
// Single-pass byte decoder: from the current sequence state and one byte,
// the next state and an optional result. Depends on u8dec_pkg.
`default_nettype none

module u8dec_decode (
   input  wire logic [u8dec_pkg::BYTE_WIDTH-1:0] byte_in,
   input  wire u8dec_pkg::dec_state_type         cur_state,
   input  wire logic [u8dec_pkg::CP_WIDTH-1:0]   replacement,
   output u8dec_pkg::dec_state_type              next_state,
   output u8dec_pkg::dec_result_type             result
);
   import u8dec_pkg::*;

   logic [CP_WIDTH-1:0] value;
   logic [1:0]          remaining_dec;
   logic                cont_bad_next;
   logic                bad;

   assign value         = {cur_state.partial[CP_WIDTH-7:0], byte_in[5:0]};
   assign remaining_dec = cur_state.remaining - 2'd1;
   assign cont_bad_next = cur_state.cont_bad || (byte_in[7:6] != 2'b10);

   always_comb begin
      bad = cont_bad_next;
      case (cur_state.seq_len)
         SEQ_LEN_2: begin
            if (value < CP_MIN_2BYTE) bad = 1'b1;
         end
         SEQ_LEN_3: begin
            if (value < CP_MIN_3BYTE ||
                (value >= SURROGATE_LOW && value <= SURROGATE_HIGH)) bad = 1'b1;
         end
         default: begin
            if (value < CP_MIN_4BYTE || value > CP_MAX) bad = 1'b1;
         end
      endcase
   end

   always_comb begin
      next_state = cur_state;
      result.valid      = 1'b0;
      result.code_point = replacement;
      result.replaced   = 1'b1;

      if (cur_state.remaining == 2'd0) begin
         if (byte_in[7] == 1'b0) begin
            result.valid      = 1'b1;
            result.code_point = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, byte_in};
            result.replaced   = 1'b0;
         end else if (byte_in[7:5] == 3'b110) begin
            if (byte_in[4:1] == 4'd0) begin
               // C0/C1 can only encode overlong ASCII
               result.valid = 1'b1;
            end else begin
               next_state.seq_len   = SEQ_LEN_2;
               next_state.remaining = SEQ_LEN_2;
               next_state.partial   = {{(CP_WIDTH-5){1'b0}}, byte_in[4:0]};
               next_state.cont_bad  = 1'b0;
            end
         end else if (byte_in[7:4] == 4'b1110) begin
            next_state.seq_len   = SEQ_LEN_3;
            next_state.remaining = SEQ_LEN_3;
            next_state.partial   = {{(CP_WIDTH-4){1'b0}}, byte_in[3:0]};
            next_state.cont_bad  = 1'b0;
         end else if (byte_in[7:3] == 5'b11110 && byte_in <= LEAD_4BYTE_MAX) begin
            next_state.seq_len   = SEQ_LEN_4;
            next_state.remaining = SEQ_LEN_4;
            next_state.partial   = {{(CP_WIDTH-3){1'b0}}, byte_in[2:0]};
            next_state.cont_bad  = 1'b0;
         end else begin
            // stray continuation or F5-FF
            result.valid = 1'b1;
         end
      end else begin
         // byte is consumed as part of the sequence whatever its form
         next_state.remaining = remaining_dec;
         next_state.partial   = value;
         next_state.cont_bad  = cont_bad_next;
         if (remaining_dec == 2'd0) begin
            next_state.seq_len  = SEQ_LEN_1;
            next_state.partial  = '0;
            next_state.cont_bad = 1'b0;
            result.valid        = 1'b1;
            if (!bad) begin
               result.code_point = value;
               result.replaced   = 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ src/utf8_stream_decoder.sv @@
// UTF-8 stream decoder top level: input byte register, decode stage with
// sequence state, result register and configuration port.
// A byte goes from the input byte register through the decode stage into
// the result register. Throughput: one byte per cycle while no byte with a
// result waits on a full result register; the decode stage is combinational.
// Reset: synchronous, active high; clears the sequence state and both
// registers' valid flags and sets the replacement value to U+FFFD.
// Depends on u8dec_pkg, u8dec_csr, u8dec_decode.
`default_nettype none

module utf8_stream_decoder (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [u8dec_pkg::BYTE_WIDTH-1:0]      req_byte_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [u8dec_pkg::CP_WIDTH-1:0]        rsp_code_point,
   output logic                                       rsp_was_replaced,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [u8dec_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [u8dec_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [u8dec_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                       pready
);
   import u8dec_pkg::*;

   logic [CP_WIDTH-1:0]   replacement;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [BYTE_WIDTH-1:0] in_byte_ff;
   logic [BYTE_WIDTH-1:0] in_byte_in;

   dec_state_type         state_ff;
   dec_state_type         state_in;
   dec_state_type         dec_next;
   dec_result_type        dec_result;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [CP_WIDTH-1:0]   out_cp_ff;
   logic [CP_WIDTH-1:0]   out_cp_in;
   logic                  out_repl_ff;
   logic                  out_repl_in;

   logic                  out_free;
   logic                  advance;
   logic                  req_take;

   u8dec_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .replacement (replacement)
   );

   u8dec_decode u_decode (
      .byte_in     (in_byte_ff),
      .cur_state   (state_ff),
      .replacement (replacement),
      .next_state  (dec_next),
      .result      (dec_result)
   );

   // a byte that makes no result never waits on the output side
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!dec_result.valid || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_byte_in;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      state_in = state_ff;
      if (advance) begin
         state_in = dec_next;
      end

      out_valid_in = out_valid_ff;
      out_cp_in    = out_cp_ff;
      out_repl_in  = out_repl_ff;
      if (advance && dec_result.valid) begin
         out_valid_in = 1'b1;
         out_cp_in    = dec_result.code_point;
         out_repl_in  = dec_result.replaced;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_cp_ff   <= out_cp_in;
      out_repl_ff <= out_repl_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_code_point   = out_cp_ff;
   assign rsp_was_replaced = out_repl_ff;

   // the count of bytes still to come never exceeds the sequence length code
   assert property (@(posedge clock) disable iff (reset)
      state_ff.remaining <= state_ff.seq_len)
      else $error("remaining count exceeds sequence length");

   // outside a sequence the gathered bits and error flag are clear
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.seq_len == SEQ_LEN_1) |-> (state_ff.partial == '0 && !state_ff.cont_bad))
      else $error("stale sequence state outside a sequence");

   // a decoded scalar is never a surrogate or above the Unicode range
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_repl_ff) |->
         (out_cp_ff <= CP_MAX && !(out_cp_ff >= SURROGATE_LOW && out_cp_ff <= SURROGATE_HIGH)))
      else $error("invalid scalar emitted without replacement");

   // a held byte stays put until the decode stage takes it
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input byte register lost a pending byte");

endmodule

`default_nettype wire
